### rtl/polyphase_sinc_resampler_top_assert.svh
// Assertion macros for the polyphase sinc resampler.
// Included by the top level; no other dependencies.
`ifndef POLYPHASE_SINC_RESAMPLER_TOP_ASSERT_SVH
`define POLYPHASE_SINC_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PSSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pssr assertion failed");

// Next-cycle implication, disabled in reset.
`define PSSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pssr assertion failed");

`endif

### rtl/pssr_pkg.sv
// Shared constants, types and codes of the polyphase sinc resampler.
// No dependencies.
package pssr_pkg;

    localparam int TAPS       = 64;
    localparam int PHASE_BITS = 12;
    localparam int MAX_RUN    = 4;

    localparam int TAP_W   = $clog2(TAPS);
    localparam int FILL_W  = $clog2(TAPS / 2 + 1);
    localparam int RUN_W   = $clog2(MAX_RUN + 1);

    localparam int COEF_AW     = 18;
    localparam int COEF_DEPTH  = TAPS << PHASE_BITS;
    localparam int COEF_RAM_AW = $clog2(COEF_DEPTH);

    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 17;
    localparam int COEF_W   = 18;
    localparam int PROD_W   = WIN_W + COEF_W;
    localparam int ACC_W    = PROD_W + TAP_W + 1;
    localparam int OUT_W    = 41;
    localparam int PEAK_W   = 40;

    localparam int FRAC_W  = 32;
    localparam int ACCUM_W = 35;
    localparam int STEP_W  = 34;
    localparam int MODE_W  = 2;
    localparam int CMD_W   = 2;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = CMD_W;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIX   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MAC,
        S_WAIT,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

### rtl/pssr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pssr_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/pssr_window.sv
// Sample window: ring buffer in RAM with per-entry valid bits, read by tap age.
// Depends on pssr_pkg and pssr_ram.
module pssr_window (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  logic                              i_push,
    input  logic signed [pssr_pkg::WIN_W-1:0] i_sample,
    input  logic                              i_rd_en,
    input  logic [pssr_pkg::TAP_W-1:0]        i_tap,
    output logic signed [pssr_pkg::WIN_W-1:0] o_data
);
    import pssr_pkg::*;

    logic [TAP_W-1:0] r_wp, n_wp;
    logic [TAPS-1:0]  r_valid;
    logic             r_rd_valid;
    logic [TAP_W:0]   rd_sum;
    logic [TAP_W-1:0] rd_addr;
    logic [WIN_W-1:0] ram_q;

    // tap 0 is the oldest entry, which sits at the write pointer
    always_comb begin
        rd_sum = {1'b0, r_wp} + {1'b0, i_tap};
        if (rd_sum >= (TAP_W + 1)'(TAPS)) begin
            rd_sum = rd_sum - (TAP_W + 1)'(TAPS);
        end
        rd_addr = rd_sum[TAP_W-1:0];
        n_wp = (r_wp == TAP_W'(TAPS - 1)) ? '0 : r_wp + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_valid <= '0;
        end else if (i_clear) begin
            r_valid <= '0;
        end else if (i_push) begin
            r_valid[r_wp] <= 1'b1;
            r_wp          <= n_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    pssr_ram #(
        .WIDTH(WIN_W),
        .DEPTH(TAPS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_push),
        .i_waddr(r_wp),
        .i_wdata(i_sample),
        .i_re   (i_rd_en),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    assign o_data = r_rd_valid ? signed'(ram_q) : '0;
endmodule

### rtl/pssr_mac.sv
// Registered multiplier and accumulator with output saturation.
// Depends on pssr_pkg.
module pssr_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pssr_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [pssr_pkg::WIN_W-1:0]  i_sample,
    input  logic signed [pssr_pkg::COEF_W-1:0] i_coef,
    output logic                               o_done,
    output logic signed [pssr_pkg::OUT_W-1:0]  o_result
);
    import pssr_pkg::*;

    t_mac_ctl                  r_ctl;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;
    logic [ACC_W-OUT_W:0]      hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.vld & r_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_sample * i_coef);
        if (r_ctl.vld) begin
            r_acc <= r_ctl.first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    always_comb begin
        hi = r_acc[ACC_W-1:OUT_W-1];
        if ((hi == '0) || (hi == '1)) begin
            o_result = r_acc[OUT_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_result = {1'b1, {(OUT_W - 1){1'b0}}};
        end else begin
            o_result = {1'b0, {(OUT_W - 1){1'b1}}};
        end
    end

    assign o_done = r_done;
endmodule

### rtl/polyphase_sinc_resampler_top.sv
// Polyphase windowed-sinc resampler, top level: control, phase and peak state.
// Depends on pssr_pkg, pssr_ram, pssr_window, pssr_mac and the assertion header.
//
// Takes one request at a time. Coefficient loads, restarts and frames that
// only fill the window complete on acceptance in S_IDLE. A frame that yields
// outputs passes through S_START; then for each output the MAC reads one
// tap per cycle from the coefficient and window memories, then drains a
// three-stage read/multiply/accumulate pipe and pushes into the output register.
// A frame yields up to MAX_RUN outputs. A result waiting in the output register
// stalls only the next push. Window entries reset to zero through valid bits;
// coefficients must be loaded before use.
`include "polyphase_sinc_resampler_top_assert.svh"

module polyphase_sinc_resampler_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config
    input  logic                                i_cfg_we,
    input  logic [pssr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pssr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // coef_address, coef_value, left_sample, right_sample, zero pad
    input  logic [pssr_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // cmd
    input  logic [pssr_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // out_sample, peak_abs, zero pad
    output logic [pssr_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);
    import pssr_pkg::*;

    localparam logic [ACCUM_W-1:0] ONE_FRAME = ACCUM_W'(1) << FRAC_W;

    t_state r_state, n_state;

    logic [MODE_W-1:0]  r_mode;
    logic [STEP_W-1:0]  r_step;
    logic [ACCUM_W-1:0] r_accum;
    logic [FILL_W-1:0]  r_fill;
    logic [PEAK_W-1:0]  r_peak;
    logic [RUN_W-1:0]   r_n;
    logic [TAP_W-1:0]   r_k;
    t_mac_ctl           r_iss;

    logic                    r_ovalid;
    logic signed [OUT_W-1:0] r_osample;
    logic [PEAK_W-1:0]       r_opeak;
    logic                    r_olast;

    logic [CMD_W-1:0]           in_cmd;
    logic [COEF_AW-1:0]         in_addr;
    logic signed [COEF_W-1:0]   in_coef;
    logic signed [SAMPLE_W-1:0] in_left, in_right;
    logic signed [WIN_W-1:0]    mono;

    logic accept, acc_load, acc_push, acc_restart, coef_we, fill_full;
    logic out_free, issue, push;
    logic accum_over;

    logic [PHASE_BITS-1:0]      ph;
    logic [COEF_AW-1:0]         coef_raddr;
    logic signed [COEF_W-1:0]   coef_q;
    logic signed [WIN_W-1:0]    win_q;
    logic                       mac_done;
    logic signed [OUT_W-1:0]    mac_y;

    logic [OUT_W-1:0]   mag;
    logic [PEAK_W-1:0]  mag_sat, peak_new;
    logic [ACCUM_W-1:0] accum_add;
    logic               run_last;

    assign in_cmd   = i_s_axis_tuser[CMD_W-1:0];
    assign in_addr  = i_s_axis_tdata[17:0];
    assign in_coef  = i_s_axis_tdata[35:18];
    assign in_left  = i_s_axis_tdata[51:36];
    assign in_right = i_s_axis_tdata[67:52];

    assign accept      = i_s_axis_tvalid & o_s_axis_tready;
    assign acc_load    = accept && (in_cmd == CMD_LOAD);
    assign acc_push    = accept && (in_cmd == CMD_PUSH);
    assign acc_restart = accept && (in_cmd == CMD_RESTART);
    assign coef_we     = acc_load && ({1'b0, in_addr} < (COEF_AW + 1)'(COEF_DEPTH));
    assign fill_full   = (r_fill == FILL_W'(TAPS / 2));
    assign out_free    = !r_ovalid || i_m_axis_tready;
    assign accum_over  = (r_accum >= ONE_FRAME);

    always_comb begin
        case (r_mode)
            MODE_LEFT:  mono = WIN_W'(in_left) <<< 1;
            MODE_RIGHT: mono = WIN_W'(in_right) <<< 1;
            default:    mono = WIN_W'(in_left) + WIN_W'(in_right);
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (acc_push && fill_full) n_state = S_START;
            S_START: n_state = accum_over ? S_IDLE : S_MAC;
            S_MAC:   if (r_k == TAP_W'(TAPS - 1)) n_state = S_WAIT;
            S_WAIT:  if (mac_done) n_state = S_PUSH;
            S_PUSH: begin
                if (out_free) n_state = run_last ? S_IDLE : S_MAC;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_s_axis_tready = 1'b0;
        issue           = 1'b0;
        push            = 1'b0;
        case (r_state)
            S_IDLE:  o_s_axis_tready = 1'b1;
            S_MAC:   issue = 1'b1;
            S_PUSH:  push = out_free;
            default: ;
        endcase
    end

    assign ph         = r_accum[FRAC_W-1:FRAC_W-PHASE_BITS];
    assign coef_raddr = COEF_AW'(COEF_AW'(ph) * COEF_AW'(TAPS)) + COEF_AW'(r_k);

    always_comb begin
        mag       = mac_y[OUT_W-1] ? OUT_W'(-mac_y) : OUT_W'(mac_y);
        mag_sat   = mag[OUT_W-1] ? '1 : mag[PEAK_W-1:0];
        peak_new  = (mag_sat > r_peak) ? mag_sat : r_peak;
        accum_add = r_accum + ACCUM_W'(r_step);
        run_last  = (r_n + 1'b1 == RUN_W'(MAX_RUN)) || (accum_add >= ONE_FRAME);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_MIX;
            r_step  <= STEP_W'(ONE_FRAME);
            r_accum <= '0;
            r_fill  <= '0;
            r_peak  <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_iss   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_index == CFG_MODE)) r_mode <= i_cfg_wdata[MODE_W-1:0];
            if (i_cfg_we && (i_cfg_index == CFG_STEP)) r_step <= i_cfg_wdata[STEP_W-1:0];

            r_iss.vld   <= issue;
            r_iss.first <= issue && (r_k == '0);
            r_iss.last  <= issue && (r_k == TAP_W'(TAPS - 1));

            if (issue) begin
                r_k <= (r_k == TAP_W'(TAPS - 1)) ? '0 : r_k + 1'b1;
            end

            if (acc_restart) begin
                r_accum <= '0;
                r_fill  <= '0;
                r_peak  <= '0;
            end else if (acc_push) begin
                r_n <= '0;
                if (!fill_full) r_fill <= r_fill + 1'b1;
            end else if ((r_state == S_START) && accum_over) begin
                r_accum <= r_accum - ONE_FRAME;
            end else if (push) begin
                r_peak <= peak_new;
                r_n    <= r_n + 1'b1;
                r_accum <= (run_last && (accum_add >= ONE_FRAME)) ?
                           accum_add - ONE_FRAME : accum_add;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_osample <= mac_y;
            r_opeak   <= peak_new;
            r_olast   <= run_last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - OUT_W - PEAK_W){1'b0}}, r_opeak, r_osample};
    assign o_m_axis_tlast  = r_olast;

    pssr_ram #(
        .WIDTH(COEF_W),
        .DEPTH(COEF_DEPTH)
    ) u_coef (
        .i_clk  (i_clk),
        .i_we   (coef_we),
        .i_waddr(COEF_RAM_AW'(in_addr)),
        .i_wdata(in_coef),
        .i_re   (issue),
        .i_raddr(COEF_RAM_AW'(coef_raddr)),
        .o_rdata(coef_q)
    );

    // window is written only on accept in S_IDLE; reads start after S_START, in S_MAC, no overlap
    pssr_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (acc_restart),
        .i_push  (acc_push),
        .i_sample(mono),
        .i_rd_en (issue),
        .i_tap   (r_k),
        .o_data  (win_q)
    );

    pssr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_iss),
        .i_sample(win_q),
        .i_coef  (coef_q),
        .o_done  (mac_done),
        .o_result(mac_y)
    );

    `PSSR_ASSERT_SAME(a_done_in_wait, i_clk, i_rst_n, mac_done, r_state == S_WAIT)
    `PSSR_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, push, !r_ovalid || i_m_axis_tready)
    `PSSR_ASSERT_SAME(a_run_bound, i_clk, i_rst_n, push, r_n < RUN_W'(MAX_RUN))
    `PSSR_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, push && run_last, r_state == S_IDLE)
endmodule
